[rtl/core/gn2_pkg.sv]
// ----------------------------------------------------------------------------
// gn2_pkg
// Shared constants for the 2D gradient noise block: field widths, codes,
// register indexes, reset values and fade constants.
// ----------------------------------------------------------------------------
package gn2_pkg;

  // default geometry
  localparam int GRID_DIM_DEF      = 64;
  localparam int POS_FRAC_BITS_DEF = 16;

  // request field widths
  localparam int ROW_W  = 6;
  localparam int GRAD_W = 16;
  localparam int POS_W  = 22;
  localparam int TDATA_IN_W  = 2 * ROW_W + 2 * GRAD_W + 2 * POS_W;
  localparam int TDATA_OUT_W = 8;

  // operation codes (carried in tuser)
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // configuration registers
  localparam int          CFG_IDX_W         = 8;
  localparam logic [7:0]  REG_AMPLITUDE     = 8'd0;
  localparam logic [7:0]  REG_HEIGHT_OFFSET = 8'd1;
  localparam logic [7:0]  AMPLITUDE_RST     = 8'd100;
  localparam logic [7:0]  HEIGHT_OFFSET_RST = 8'd100;

  // fade polynomial 6t^5 - 15t^4 + 10t^3 in Q16
  localparam logic [16:0] ONE_Q16  = 17'h10000;
  localparam logic [20:0] TEN_Q16  = 21'd655360;
  localparam int          FADE_C6  = 6;
  localparam int          FADE_C15 = 15;

endpackage

[rtl/core/gn2_ram.sv]
// ----------------------------------------------------------------------------
// gn2_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data with read enable.
// ----------------------------------------------------------------------------
module gn2_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/gn2_front.sv]
// ----------------------------------------------------------------------------
// gn2_front
// Accepts requests, decodes them (gradient write or evaluate), checks the
// grid bounds and holds them in a four-entry queue for the back end.
// ----------------------------------------------------------------------------
module gn2_front #(
  parameter int GRID_DIM      = gn2_pkg::GRID_DIM_DEF,
  parameter int POS_FRAC_BITS = gn2_pkg::POS_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [gn2_pkg::TDATA_IN_W-1:0]        s_tdata,
  input  logic                                  s_tuser,
  output logic                                  q_valid,
  input  logic                                  q_pop,
  output logic                                  q_write,
  output logic [$clog2(GRID_DIM*GRID_DIM)-1:0]  q_waddr,
  output logic [2*gn2_pkg::GRAD_W-1:0]          q_grad,
  output logic [$clog2(GRID_DIM)-1:0]           q_ix,
  output logic [$clog2(GRID_DIM)-1:0]           q_iy,
  output logic [POS_FRAC_BITS-1:0]              q_fx,
  output logic [POS_FRAC_BITS-1:0]              q_fy,
  output logic                                  q_oor
);

  localparam int AW    = $clog2(GRID_DIM * GRID_DIM);
  localparam int IW    = $clog2(GRID_DIM);
  localparam int F     = POS_FRAC_BITS;
  localparam int GW    = 2 * gn2_pkg::GRAD_W;
  localparam int DEPTH = 4;
  localparam int PTR_W = 2;

  // request fields
  logic [gn2_pkg::ROW_W-1:0] grid_row, grid_col;
  logic [GW-1:0]             grad;
  logic [47:0]               pxe, pye;
  logic [31:0]               ix32, iy32;
  logic                      row_ok, oor, push;
  logic [AW-1:0]             waddr;

  assign grid_row = s_tdata[5:0];
  assign grid_col = s_tdata[11:6];
  assign grad     = s_tdata[43:12];
  assign pxe      = 48'(s_tdata[65:44]);
  assign pye      = 48'(s_tdata[87:66]);

  // classification
  always_comb begin
    row_ok = (32'(grid_row) < GRID_DIM) && (32'(grid_col) < GRID_DIM);
    waddr  = AW'(32'(grid_row) * GRID_DIM + 32'(grid_col));
    ix32   = 32'(pxe >> F);
    iy32   = 32'(pye >> F);
    oor    = (({1'b0, ix32} + 33'd1) >= 33'(GRID_DIM)) ||
             (({1'b0, iy32} + 33'd1) >= 33'(GRID_DIM));
  end

  // queue storage
  logic          e_write [DEPTH];
  logic [AW-1:0] e_waddr [DEPTH];
  logic [GW-1:0] e_grad  [DEPTH];
  logic [IW-1:0] e_ix    [DEPTH];
  logic [IW-1:0] e_iy    [DEPTH];
  logic [F-1:0]  e_fx    [DEPTH];
  logic [F-1:0]  e_fy    [DEPTH];
  logic          e_oor   [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [PTR_W:0]   count;
  logic             pop;

  assign s_tready = (count != 3'(DEPTH));
  // an out-of-grid write does nothing, so it is dropped here
  assign push = s_tvalid && s_tready && !((s_tuser == gn2_pkg::OP_WRITE) && !row_ok);
  assign q_valid = (count != '0);
  assign pop = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      e_write[wptr] <= (s_tuser == gn2_pkg::OP_WRITE);
      e_waddr[wptr] <= waddr;
      e_grad[wptr]  <= grad;
      e_ix[wptr]    <= oor ? '0 : ix32[IW-1:0];
      e_iy[wptr]    <= oor ? '0 : iy32[IW-1:0];
      e_fx[wptr]    <= pxe[F-1:0];
      e_fy[wptr]    <= pye[F-1:0];
      e_oor[wptr]   <= oor;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + (push ? 3'd1 : 3'd0) - (pop ? 3'd1 : 3'd0);
    end
  end

  assign q_write = e_write[rptr];
  assign q_waddr = e_waddr[rptr];
  assign q_grad  = e_grad[rptr];
  assign q_ix    = e_ix[rptr];
  assign q_iy    = e_iy[rptr];
  assign q_fx    = e_fx[rptr];
  assign q_fy    = e_fy[rptr];
  assign q_oor   = e_oor[rptr];

endmodule

[rtl/core/gn2_back.sv]
// ----------------------------------------------------------------------------
// gn2_back
// Execution pipeline: gradient table writes, four corner reads, dot
// products, quintic fade, two blends, scaling and saturation. Eleven
// stages, all advancing together unless the result register is stalled.
// ----------------------------------------------------------------------------
module gn2_back #(
  parameter int GRID_DIM      = gn2_pkg::GRID_DIM_DEF,
  parameter int POS_FRAC_BITS = gn2_pkg::POS_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_valid,
  output logic                                  q_pop,
  input  logic                                  q_write,
  input  logic [$clog2(GRID_DIM*GRID_DIM)-1:0]  q_waddr,
  input  logic [2*gn2_pkg::GRAD_W-1:0]          q_grad,
  input  logic [$clog2(GRID_DIM)-1:0]           q_ix,
  input  logic [$clog2(GRID_DIM)-1:0]           q_iy,
  input  logic [POS_FRAC_BITS-1:0]              q_fx,
  input  logic [POS_FRAC_BITS-1:0]              q_fy,
  input  logic                                  q_oor,
  input  logic [7:0]                            amplitude,
  input  logic [7:0]                            height_offset,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [gn2_pkg::TDATA_OUT_W-1:0]       m_tdata,
  output logic                                  m_tuser
);

  localparam int DEPTH = GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int F     = POS_FRAC_BITS;
  localparam int GW    = 2 * gn2_pkg::GRAD_W;
  localparam int DXW   = F + 2;          // corner offset
  localparam int MW    = DXW + 16;       // offset * gradient component
  localparam int DW    = F + 19;         // dot product / blended value
  localparam int DFW   = DW + 1;         // blend difference
  localparam int HW    = DFW - 18;       // upper slice of difference
  localparam int PW    = DW + 19;        // difference * weight
  localparam int SW    = DW + 10;        // scaled noise
  localparam int NST   = 11;

  logic en;
  logic [NST:1] vld, oor_sr;

  // whole pipeline moves unless the result is held
  assign en    = !m_tvalid || m_tready;
  assign q_pop = en && q_valid;

  // ---- stage 0: table write or corner read issue ----
  logic [AW-1:0] base;
  logic [AW-1:0] raddr [4];
  logic [GW-1:0] g     [4];
  logic          we;

  assign we   = q_pop && q_write;
  assign base = AW'(32'(q_iy) * GRID_DIM + 32'(q_ix));
  assign raddr[0] = base;
  assign raddr[1] = base + AW'(1);
  assign raddr[2] = base + AW'(GRID_DIM);
  assign raddr[3] = base + AW'(GRID_DIM + 1);

  // one table copy per corner read port, all written together
  for (genvar c = 0; c < 4; c++) begin : g_tab
    gn2_ram #(.WIDTH(GW), .DEPTH(DEPTH)) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (q_waddr),
      .wdata (q_grad),
      .re    (en),
      .raddr (raddr[c]),
      .rdata (g[c])
    );
  end

  // control shift registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-1:1], q_pop && !q_write};
    end
  end

  always_ff @(posedge clk) begin
    if (en) oor_sr <= {oor_sr[NST-1:1], q_oor};
  end

  // ---- stage 1: fraction and fade input ----
  logic [F-1:0]  fx1, fy1;
  logic [15:0]   tx1, ty1;
  always_ff @(posedge clk) begin
    if (en) begin
      fx1 <= q_fx;
      fy1 <= q_fy;
      tx1 <= 16'({q_fx, 16'h0} >> F);
      ty1 <= 16'({q_fy, 16'h0} >> F);
    end
  end

  // ---- stage 2: offset * gradient products, t^2 ----
  logic signed [DXW-1:0] dx0, dx1, dy0, dy1;
  logic signed [DXW-1:0] ox [4];
  logic signed [DXW-1:0] oy [4];
  logic signed [MW-1:0]  pxg2 [4];
  logic signed [MW-1:0]  pyg2 [4];
  logic [15:0] tx2, ty2, t2x2, t2y2;

  always_comb begin
    dx0 = $signed({2'b00, fx1});
    dy0 = $signed({2'b00, fy1});
    dx1 = dx0 - $signed({2'b01, {F{1'b0}}});
    dy1 = dy0 - $signed({2'b01, {F{1'b0}}});
    ox[0] = dx0; oy[0] = dy0;
    ox[1] = dx1; oy[1] = dy0;
    ox[2] = dx0; oy[2] = dy1;
    ox[3] = dx1; oy[3] = dy1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        pxg2[c] <= MW'(ox[c]) * MW'($signed(g[c][15:0]));
        pyg2[c] <= MW'(oy[c]) * MW'($signed(g[c][31:16]));
      end
      tx2  <= tx1;
      ty2  <= ty1;
      t2x2 <= 16'((32'(tx1) * 32'(tx1)) >> 16);
      t2y2 <= 16'((32'(ty1) * 32'(ty1)) >> 16);
    end
  end

  // ---- stage 3: dot products, t^3 and fade polynomial ----
  logic signed [DW-1:0] dot3 [4];
  logic [15:0] t3x3, t3y3;
  logic [20:0] px3, py3;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        dot3[c] <= DW'(pxg2[c]) + DW'(pyg2[c]);
      end
      t3x3 <= 16'((32'(t2x2) * 32'(tx2)) >> 16);
      t3y3 <= 16'((32'(t2y2) * 32'(ty2)) >> 16);
      px3  <= 21'(gn2_pkg::FADE_C6 * 32'(t2x2)) + gn2_pkg::TEN_Q16
              - 21'(gn2_pkg::FADE_C15 * 32'(tx2));
      py3  <= 21'(gn2_pkg::FADE_C6 * 32'(t2y2)) + gn2_pkg::TEN_Q16
              - 21'(gn2_pkg::FADE_C15 * 32'(ty2));
    end
  end

  // ---- stage 4: x differences, fade weights ----
  logic signed [DW-1:0]  a0_4, a1_4;
  logic signed [DFW-1:0] dt4, db4;
  logic [16:0] wx4, wy4;
  logic [19:0] rx, ry;
  always_comb begin
    rx = 20'((40'(t3x3) * 40'(px3)) >> 16);
    ry = 20'((40'(t3y3) * 40'(py3)) >> 16);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a0_4 <= dot3[0];
      a1_4 <= dot3[2];
      dt4  <= DFW'(dot3[1]) - DFW'(dot3[0]);
      db4  <= DFW'(dot3[3]) - DFW'(dot3[2]);
      wx4  <= (rx > 20'(gn2_pkg::ONE_Q16)) ? gn2_pkg::ONE_Q16 : rx[16:0];
      wy4  <= (ry > 20'(gn2_pkg::ONE_Q16)) ? gn2_pkg::ONE_Q16 : ry[16:0];
    end
  end

  // ---- stage 5: x blend partial products ----
  logic signed [DW-1:0]    a0_5, a1_5;
  logic signed [HW+17:0]   hpt5, hpb5;
  logic signed [36:0]      lpt5, lpb5;
  logic [16:0]             wy5;
  always_ff @(posedge clk) begin
    if (en) begin
      a0_5 <= a0_4;
      a1_5 <= a1_4;
      hpt5 <= (HW+18)'($signed(dt4[DFW-1:18])) * (HW+18)'($signed({1'b0, wx4}));
      hpb5 <= (HW+18)'($signed(db4[DFW-1:18])) * (HW+18)'($signed({1'b0, wx4}));
      lpt5 <= 37'($signed({1'b0, dt4[17:0]})) * 37'($signed({1'b0, wx4}));
      lpb5 <= 37'($signed({1'b0, db4[17:0]})) * 37'($signed({1'b0, wx4}));
      wy5  <= wy4;
    end
  end

  // ---- stage 6: top and bottom edge values ----
  logic signed [PW-1:0] st, sb;
  logic signed [DW-1:0] top6, bot6;
  logic [16:0]          wy6;
  always_comb begin
    st = (PW'(hpt5) <<< 18) + PW'(lpt5);
    sb = (PW'(hpb5) <<< 18) + PW'(lpb5);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      top6 <= a0_5 + DW'(st >>> 16);
      bot6 <= a1_5 + DW'(sb >>> 16);
      wy6  <= wy5;
    end
  end

  // ---- stage 7: y difference ----
  logic signed [DW-1:0]  top7;
  logic signed [DFW-1:0] dv7;
  logic [16:0]           wy7;
  always_ff @(posedge clk) begin
    if (en) begin
      top7 <= top6;
      dv7  <= DFW'(bot6) - DFW'(top6);
      wy7  <= wy6;
    end
  end

  // ---- stage 8: y blend partial products ----
  logic signed [DW-1:0]  top8;
  logic signed [HW+17:0] hpv8;
  logic signed [36:0]    lpv8;
  always_ff @(posedge clk) begin
    if (en) begin
      top8 <= top7;
      hpv8 <= (HW+18)'($signed(dv7[DFW-1:18])) * (HW+18)'($signed({1'b0, wy7}));
      lpv8 <= 37'($signed({1'b0, dv7[17:0]})) * 37'($signed({1'b0, wy7}));
    end
  end

  // ---- stage 9: noise ----
  logic signed [PW-1:0] sv;
  logic signed [DW-1:0] noise9;
  assign sv = (PW'(hpv8) <<< 18) + PW'(lpv8);
  always_ff @(posedge clk) begin
    if (en) noise9 <= top8 + DW'(sv >>> 16);
  end

  // ---- stage 10: scale and offset ----
  logic signed [SW-1:0] sc10;
  always_ff @(posedge clk) begin
    if (en) begin
      sc10 <= SW'(noise9) * SW'($signed({1'b0, amplitude}))
              + SW'($signed({1'b0, height_offset, {(F+14){1'b0}}}));
    end
  end

  // ---- stage 11: floor, saturate, result register ----
  logic signed [SW-F-15:0] hi;
  logic [7:0]              hgt;
  assign hi = sc10[SW-1:F+14];
  always_comb begin
    if (oor_sr[10] || (hi < 0)) begin
      hgt = 8'd0;
    end else if (hi > 255) begin
      hgt = 8'd255;
    end else begin
      hgt = hi[7:0];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= hgt;
      m_tuser <= oor_sr[10];
    end
  end

  assign m_tvalid = vld[NST];

  // ---- checks ----
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("out-of-range result with nonzero height");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    q_pop && q_write |=> !vld[1])
    else $error("gradient write started a result");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> vld == $past(vld))
    else $error("pipeline moved while result stalled");

endmodule

[rtl/core/gradient_noise_2d.sv]
// ----------------------------------------------------------------------------
// gradient_noise_2d
// Two-dimensional gradient noise with quintic fade: gradient table writes
// and height evaluation over a stream interface.
// ----------------------------------------------------------------------------
// Takes one request per clock while the queue has room and returns one height
// per evaluate request at one per clock, sustained as long as m_tready stays
// high. A request passes a four-entry queue and then an eleven-stage pipeline;
// the output register sets the pace, and when it stalls the pipeline and then
// the queue hold. Gradient writes return nothing and go to four copies of the
// gradient table (one per cell corner), so the four corners of a cell are
// read together. Entries never written read back as undefined gradients.
// amplitude and height_offset (register 0 and 1) should only be written
// while idle.
module gradient_noise_2d #(
  parameter int GRID_DIM      = gn2_pkg::GRID_DIM_DEF,
  parameter int POS_FRAC_BITS = gn2_pkg::POS_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // request: tdata = grid_row, grid_col, grad_x, grad_y, pos_x, pos_y
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [gn2_pkg::TDATA_IN_W-1:0]      s_tdata,
  input  logic                                s_tuser,   // operation
  // result: tdata = height
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [gn2_pkg::TDATA_OUT_W-1:0]     m_tdata,
  output logic                                m_tuser,   // out_of_range
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gn2_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [7:0]                          cfg_data
);

  localparam int AW = $clog2(GRID_DIM * GRID_DIM);
  localparam int IW = $clog2(GRID_DIM);
  localparam int F  = POS_FRAC_BITS;

  // configuration registers
  logic [7:0] amplitude, height_offset;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude     <= gn2_pkg::AMPLITUDE_RST;
      height_offset <= gn2_pkg::HEIGHT_OFFSET_RST;
    end else if (cfg_valid) begin
      if (cfg_index == gn2_pkg::REG_AMPLITUDE)     amplitude     <= cfg_data;
      if (cfg_index == gn2_pkg::REG_HEIGHT_OFFSET) height_offset <= cfg_data;
    end
  end

  // queue between front and back
  logic                           q_valid, q_pop, q_write, q_oor;
  logic [AW-1:0]                  q_waddr;
  logic [2*gn2_pkg::GRAD_W-1:0]   q_grad;
  logic [IW-1:0]                  q_ix, q_iy;
  logic [F-1:0]                   q_fx, q_fy;

  gn2_front #(.GRID_DIM(GRID_DIM), .POS_FRAC_BITS(POS_FRAC_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_write  (q_write),
    .q_waddr  (q_waddr),
    .q_grad   (q_grad),
    .q_ix     (q_ix),
    .q_iy     (q_iy),
    .q_fx     (q_fx),
    .q_fy     (q_fy),
    .q_oor    (q_oor)
  );

  gn2_back #(.GRID_DIM(GRID_DIM), .POS_FRAC_BITS(POS_FRAC_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_write       (q_write),
    .q_waddr       (q_waddr),
    .q_grad        (q_grad),
    .q_ix          (q_ix),
    .q_iy          (q_iy),
    .q_fx          (q_fx),
    .q_fy          (q_fy),
    .q_oor         (q_oor),
    .amplitude     (amplitude),
    .height_offset (height_offset),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser)
  );

endmodule

[test/gn2_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2_checker
// Watches the request, result and configuration channels of the gradient
// noise block, predicts each height and compares it with what comes out.
// ----------------------------------------------------------------------------
module gn2_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [gn2_pkg::TDATA_IN_W-1:0]  s_tdata,
  input  logic                            s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [gn2_pkg::TDATA_OUT_W-1:0] m_tdata,
  input  logic                            m_tuser,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [gn2_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                      cfg_data,
  output int                              fail_count,
  output int                              heights_pending
);

  localparam int GDIM = gn2_pkg::GRID_DIM_DEF;
  localparam int FB   = gn2_pkg::POS_FRAC_BITS_DEF;
  localparam int RW   = gn2_pkg::ROW_W;
  localparam int GW   = gn2_pkg::GRAD_W;
  localparam int PW   = gn2_pkg::POS_W;

  typedef struct packed {
    logic       oor;
    logic [7:0] height;
  } height_t;

  logic signed [15:0] grad_x_tab [GDIM*GDIM];
  logic signed [15:0] grad_y_tab [GDIM*GDIM];
  logic [7:0] amp, hoff;
  height_t heights_due [$];

  // floor division by 2^s for signed values
  function automatic longint fdiv(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint fade(longint f);
    longint t, t2, t3, p, r;
    t  = (f >> (FB - 16)) & 64'hFFFF;
    t2 = (t * t) >> 16;
    t3 = (t2 * t) >> 16;
    p  = 6 * t2 + 10 * 65536 - 15 * t;
    r  = (t3 * p) >> 16;
    return (r > 65536) ? 65536 : r;
  endfunction

  function automatic longint corner(int row, int col, longint dx, longint dy);
    int k;
    k = row * GDIM + col;
    return dx * longint'(grad_x_tab[k]) + dy * longint'(grad_y_tab[k]);
  endfunction

  function automatic longint mix(longint a, longint b, longint w);
    return a + fdiv((b - a) * w, 16);
  endfunction

  function automatic height_t height_of(logic [PW-1:0] px, logic [PW-1:0] py);
    height_t r;
    int ix, iy;
    longint fx, fy, d00, d10, d01, d11, wx, wy, top, bot, nz, h;
    ix = px >> FB;
    iy = py >> FB;
    if (ix + 1 >= GDIM || iy + 1 >= GDIM) begin
      r.height = 8'd0;
      r.oor    = 1'b1;
      return r;
    end
    fx  = px & ((1 << FB) - 1);
    fy  = py & ((1 << FB) - 1);
    d00 = corner(iy, ix, fx, fy);
    d10 = corner(iy, ix + 1, fx - (1 << FB), fy);
    d01 = corner(iy + 1, ix, fx, fy - (1 << FB));
    d11 = corner(iy + 1, ix + 1, fx - (1 << FB), fy - (1 << FB));
    wx  = fade(fx);
    wy  = fade(fy);
    top = mix(d00, d10, wx);
    bot = mix(d01, d11, wx);
    nz  = mix(top, bot, wy);
    h   = fdiv(nz * longint'(amp) + (longint'(hoff) << (FB + 14)), FB + 14);
    if (h < 0) h = 0;
    if (h > 255) h = 255;
    r.height = h[7:0];
    r.oor    = 1'b0;
    return r;
  endfunction

  // track requests, config writes and results
  always @(posedge clk) begin
    logic [RW-1:0] row, col;
    height_t exp_h;
    if (rst) begin
      amp  <= gn2_pkg::AMPLITUDE_RST;
      hoff <= gn2_pkg::HEIGHT_OFFSET_RST;
      fail_count = 0;
      heights_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == gn2_pkg::REG_AMPLITUDE) amp <= cfg_data;
        else if (cfg_index == gn2_pkg::REG_HEIGHT_OFFSET) hoff <= cfg_data;
      end
      if (m_tvalid && m_tready) begin
        if (heights_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected height: exp none got %0d/%0b", m_tdata, m_tuser);
        end else begin
          exp_h = heights_due.pop_front();
          if (exp_h.height !== m_tdata || exp_h.oor !== m_tuser) begin
            fail_count++;
            if (fail_count <= 10)
              $display("height mismatch: exp %0d/%0b got %0d/%0b",
                       exp_h.height, exp_h.oor, m_tdata, m_tuser);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == gn2_pkg::OP_WRITE) begin
          row = s_tdata[RW-1:0];
          col = s_tdata[2*RW-1:RW];
          if (row < GDIM && col < GDIM) begin
            grad_x_tab[row*GDIM+col] = s_tdata[2*RW +: GW];
            grad_y_tab[row*GDIM+col] = s_tdata[2*RW+GW +: GW];
          end
        end else begin
          heights_due = {heights_due, height_of(s_tdata[2*RW+2*GW +: PW],
                                                s_tdata[2*RW+2*GW+PW +: PW])};
        end
      end
    end
    heights_pending = heights_due.size();
  end
endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Fills a corner block of the gradient grid and the far corner cell, then
// streams directed and random evaluate and write requests under several
// amplitude/offset settings with random gaps and output stalls; the checker
// predicts and compares every height.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG = 20000;
  localparam int RW       = gn2_pkg::ROW_W;
  localparam int PW       = gn2_pkg::POS_W;
  localparam int FILL_DIM = 16;
  localparam logic [gn2_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0, s_tready, s_tuser = 1'b0;
  logic [gn2_pkg::TDATA_IN_W-1:0] s_tdata = '0;
  logic m_tvalid, m_tready = 1'b0, m_tuser;
  logic [gn2_pkg::TDATA_OUT_W-1:0] m_tdata;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [gn2_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  int fail_count, heights_pending;
  int idle_cycles = 0;
  bit stall_mode = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gradient_noise_2d i_dut (.*);

  gn2_checker i_chk (.*);

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (!rst) idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver stall pattern; some stretches never stall
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode = ~stall_mode;
    m_tready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  task automatic send_req(logic op, logic [RW-1:0] row, logic [RW-1:0] col,
                          logic [15:0] gx, logic [15:0] gy,
                          logic [PW-1:0] px, logic [PW-1:0] py);
    s_tuser  <= op;
    s_tdata  <= {py, px, gy, gx, col, row};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // burst of a random length, then a random gap
  int burst_left = 0;
  task automatic pace;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 12)) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
  endtask

  task automatic write_grad(int row, int col, logic [15:0] gx, logic [15:0] gy);
    pace();
    send_req(gn2_pkg::OP_WRITE, RW'(row), RW'(col), gx, gy,
             PW'($urandom), PW'($urandom));
  endtask

  task automatic eval_at(logic [PW-1:0] px, logic [PW-1:0] py);
    pace();
    send_req(gn2_pkg::OP_EVAL, RW'($urandom), RW'($urandom),
             16'($urandom), 16'($urandom), px, py);
  endtask

  function automatic logic [15:0] rand_grad();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'h7FFF;
      3: return 16'h8000;
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  // keep positions inside the filled block mostly, sometimes past the edge
  function automatic logic [PW-1:0] rand_pos();
    logic [PW-1:0] p;
    p = PW'($urandom);
    if ($urandom_range(0, 9) != 0) p[21:16] = 6'($urandom_range(0, FILL_DIM - 2));
    else p[21:16] = 6'd63;
    return p;
  endfunction

  task automatic set_reg(logic [gn2_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (heights_pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  initial begin
    logic [7:0] amps [5] = '{8'd100, 8'd0, 8'd255, 8'd1, 8'd180};
    logic [7:0] offs [5] = '{8'd100, 8'd255, 8'd0, 8'd128, 8'd37};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every entry that an evaluate reads gets written first
    for (int r = 0; r < FILL_DIM; r++)
      for (int c = 0; c < FILL_DIM; c++)
        write_grad(r, c, rand_grad(), rand_grad());
    for (int r = 62; r < 64; r++)
      for (int c = 62; c < 64; c++)
        write_grad(r, c, rand_grad(), rand_grad());

    // directed: extremes, zero fraction, edges, out-of-grid
    eval_at(22'd0, 22'd0);
    eval_at(22'h3EFFFF, 22'h3EFFFF);
    eval_at(22'h3F0000, 22'd0);
    eval_at(22'd0, 22'h3F0000);
    eval_at(22'h3FFFFF, 22'h3FFFFF);
    eval_at(22'h008000, 22'h008000);
    eval_at(22'h00FFFF, 22'h000001);
    eval_at(22'h051234, 22'h0A0000);
    write_grad(5, 5, 16'h7FFF, 16'h7FFF);
    write_grad(5, 6, 16'h8000, 16'h8000);
    write_grad(6, 5, 16'h7FFF, 16'h8000);
    write_grad(6, 6, 16'h8000, 16'h7FFF);
    eval_at(22'h05C000, 22'h054000);
    eval_at(22'h05FFFF, 22'h05FFFF);
    write_grad(63, 63, 16'h4000, 16'hC000);
    eval_at(22'h3E8000, 22'h3E8000);

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      set_reg(gn2_pkg::REG_AMPLITUDE, amps[ph]);
      set_reg(gn2_pkg::REG_HEIGHT_OFFSET, offs[ph]);
      if (ph == 4) set_reg(REG_UNUSED, 8'hFF);
      for (int n = 0; n < 240; n++) begin
        if ($urandom_range(0, 4) == 0)
          write_grad($urandom_range(0, 63), $urandom_range(0, 63), rand_grad(), rand_grad());
        else
          eval_at(rand_pos(), rand_pos());
      end
    end
    drain();

    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule

[files.f]
rtl/core/gn2_pkg.sv
rtl/core/gn2_ram.sv
rtl/core/gn2_front.sv
rtl/core/gn2_back.sv
rtl/core/gradient_noise_2d.sv
test/gn2_checker.sv
test/tb.sv
